/* design/spi_pkg.sv */
// shared widths and item types for the segment pair intersection block
// no dependencies
package spi_pkg;

  localparam int COORD_BITS    = 16;
  localparam int FRAC_OUT_BITS = 16;
  localparam int COORD_FRAC    = COORD_BITS - 8;
  localparam int OUT_BITS      = 8 + FRAC_OUT_BITS;

  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int CROSS_BITS = PROD_BITS + 1;
  localparam int TOP_BITS   = CROSS_BITS + DIFF_BITS + 1;
  localparam int SCALE_SH   = FRAC_OUT_BITS - COORD_FRAC;
  localparam int NUM_BITS   = TOP_BITS + SCALE_SH;
  localparam int QUO_BITS   = OUT_BITS;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic                  hit;
    logic                  neg_x;
    logic                  neg_y;
    logic [NUM_BITS-1:0]   num_x;
    logic [NUM_BITS-1:0]   num_y;
    logic [CROSS_BITS-1:0] den;
  } div_job_t;

  typedef struct packed {
    logic                  hit;
    logic                  neg_x;
    logic                  neg_y;
    logic [NUM_BITS-1:0]   rem_x;
    logic [NUM_BITS-1:0]   rem_y;
    logic [CROSS_BITS-1:0] den;
    logic [QUO_BITS-1:0]   quo_x;
    logic [QUO_BITS-1:0]   quo_y;
  } div_stage_t;

endpackage

/* design/spi_front.sv */
// front pipeline: differences, cross products, hit test and scaled numerators
// depends on spi_pkg
module spi_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [8*spi_pkg::COORD_BITS-1:0]      in_data,
  output logic                                  job_valid,
  input  logic                                  job_full,
  output spi_pkg::div_job_t                     job
);

  localparam int CB = spi_pkg::COORD_BITS;
  localparam int DB = spi_pkg::DIFF_BITS;
  localparam int PB = spi_pkg::PROD_BITS;
  localparam int XB = spi_pkg::CROSS_BITS;
  localparam int TB = spi_pkg::TOP_BITS;
  localparam int NB = spi_pkg::NUM_BITS;

  logic en;
  logic v1, v2, v3, v4, v5;

  logic signed [CB-1:0] px, py, ex, ey, qx, qy, fx, fy;

  logic signed [CB-1:0] px1, py1;
  logic signed [DB-1:0] rx1, ry1, sx1, sy1, dx1, dy1;

  logic signed [CB-1:0] px2, py2;
  logic signed [DB-1:0] rx2, ry2;
  logic signed [PB-1:0] p_rs0, p_rs1, p_tn0, p_tn1, p_un0, p_un1;

  logic signed [CB-1:0] px3, py3;
  logic signed [DB-1:0] rx3, ry3;
  logic signed [XB-1:0] rs3, tn3, un3;

  logic                 hit4;
  logic signed [XB-1:0] rs4;
  logic signed [TB-1:0] bx4, by4, mx4, my4;

  logic                 t_ok, u_ok;
  logic signed [TB-1:0] top_x, top_y;
  logic        [TB-1:0] mag_x, mag_y;
  logic        [XB-1:0] mag_d;

  assign en       = !v5 || !job_full;
  assign in_ready = en;

  assign px = in_data[0*CB +: CB];
  assign py = in_data[1*CB +: CB];
  assign ex = in_data[2*CB +: CB];
  assign ey = in_data[3*CB +: CB];
  assign qx = in_data[4*CB +: CB];
  assign qy = in_data[5*CB +: CB];
  assign fx = in_data[6*CB +: CB];
  assign fy = in_data[7*CB +: CB];

  always_comb begin
    if (rs3 > 0) begin
      t_ok = (tn3 >= 0) && (tn3 <= rs3);
      u_ok = (un3 >= 0) && (un3 <= rs3);
    end else begin
      t_ok = (tn3 <= 0) && (tn3 >= rs3);
      u_ok = (un3 <= 0) && (un3 >= rs3);
    end
  end

  assign top_x = bx4 + mx4;
  assign top_y = by4 + my4;
  assign mag_x = top_x[TB-1] ? TB'(-top_x) : TB'(top_x);
  assign mag_y = top_y[TB-1] ? TB'(-top_y) : TB'(top_y);
  assign mag_d = rs4[XB-1] ? XB'(-rs4) : XB'(rs4);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1 <= px;
      py1 <= py;
      rx1 <= DB'(ex) - DB'(px);
      ry1 <= DB'(ey) - DB'(py);
      sx1 <= DB'(fx) - DB'(qx);
      sy1 <= DB'(fy) - DB'(qy);
      dx1 <= DB'(qx) - DB'(px);
      dy1 <= DB'(qy) - DB'(py);

      px2   <= px1;
      py2   <= py1;
      rx2   <= rx1;
      ry2   <= ry1;
      p_rs0 <= PB'(rx1) * PB'(sy1);
      p_rs1 <= PB'(ry1) * PB'(sx1);
      p_tn0 <= PB'(dx1) * PB'(sy1);
      p_tn1 <= PB'(dy1) * PB'(sx1);
      p_un0 <= PB'(dx1) * PB'(ry1);
      p_un1 <= PB'(dy1) * PB'(rx1);

      px3 <= px2;
      py3 <= py2;
      rx3 <= rx2;
      ry3 <= ry2;
      rs3 <= XB'(p_rs0) - XB'(p_rs1);
      tn3 <= XB'(p_tn0) - XB'(p_tn1);
      un3 <= XB'(p_un0) - XB'(p_un1);

      hit4 <= (rs3 != 0) && t_ok && u_ok;
      rs4  <= rs3;
      bx4  <= TB'(px3) * TB'(rs3);
      by4  <= TB'(py3) * TB'(rs3);
      mx4  <= TB'(tn3) * TB'(rx3);
      my4  <= TB'(tn3) * TB'(ry3);

      job.hit   <= hit4;
      job.neg_x <= top_x[TB-1] ^ rs4[XB-1];
      job.neg_y <= top_y[TB-1] ^ rs4[XB-1];
      job.num_x <= NB'(mag_x) << spi_pkg::SCALE_SH;
      job.num_y <= NB'(mag_y) << spi_pkg::SCALE_SH;
      job.den   <= mag_d;
    end
  end

  assign job_valid = v5;

endmodule

/* design/spi_fifo.sv */
// short queue of division jobs between front and back
// depends on spi_pkg
module spi_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  spi_pkg::div_job_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output spi_pkg::div_job_t pop_data
);

  localparam int AW = spi_pkg::FIFO_AW;

  spi_pkg::div_job_t mem [spi_pkg::FIFO_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic          do_push, do_pop;

  assign full     = count == (AW+1)'(spi_pkg::FIFO_DEPTH);
  assign empty    = count == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

endmodule

/* design/spi_back.sv */
// back pipeline: one quotient bit per stage restoring division and output register
// depends on spi_pkg
module spi_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          job_avail,
  output logic                          job_pop,
  input  spi_pkg::div_job_t             job,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit,
  output logic [spi_pkg::OUT_BITS-1:0]  out_x,
  output logic [spi_pkg::OUT_BITS-1:0]  out_y
);

  localparam int QB = spi_pkg::QUO_BITS;
  localparam int NB = spi_pkg::NUM_BITS;

  logic                en;
  logic                sv [QB+1];
  spi_pkg::div_stage_t st [QB+1];
  spi_pkg::div_stage_t nx [QB];
  spi_pkg::div_stage_t fin;

  assign en      = !out_valid || out_ready;
  assign job_pop = en && job_avail;
  assign fin     = st[QB];

  always_comb begin
    logic [NB-1:0] trial;
    for (int j = 0; j < QB; j++) begin
      nx[j] = st[j];
      trial = NB'(st[j].den) << (QB - 1 - j);
      if (st[j].rem_x >= trial) begin
        nx[j].rem_x = st[j].rem_x - trial;
        nx[j].quo_x[QB-1-j] = 1'b1;
      end
      if (st[j].rem_y >= trial) begin
        nx[j].rem_y = st[j].rem_y - trial;
        nx[j].quo_y[QB-1-j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= QB; j++) sv[j] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      sv[0] <= job_avail;
      for (int j = 0; j < QB; j++) sv[j+1] <= sv[j];
      out_valid <= sv[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].hit   <= job.hit;
      st[0].neg_x <= job.neg_x;
      st[0].neg_y <= job.neg_y;
      st[0].rem_x <= job.num_x;
      st[0].rem_y <= job.num_y;
      st[0].den   <= job.den;
      st[0].quo_x <= '0;
      st[0].quo_y <= '0;
      for (int j = 0; j < QB; j++) st[j+1] <= nx[j];
      out_hit <= fin.hit;
      if (fin.hit) begin
        out_x <= fin.neg_x ? QB'(-fin.quo_x) : fin.quo_x;
        out_y <= fin.neg_y ? QB'(-fin.quo_y) : fin.quo_y;
      end else begin
        out_x <= '0;
        out_y <= '0;
      end
    end
  end

endmodule

/* design/segment_pair_intersection.sv */
// top level of the 2-d segment pair intersection engine
// depends on spi_pkg, spi_front, spi_fifo, spi_back
//
// usage
//   s_* channel takes one segment pair per item, eight signed q8.8 coordinates
//   m_* channel gives one result per item: hit flag in tuser, point in tdata
//   the point is p + t*r in signed q8.16, truncated toward zero, zero on a miss
//   parallel, collinear and degenerate pairs give no hit
// throughput
//   one item per cycle while nothing stalls; then every pipeline stage moves on each clock
// pipeline path
//   5 front stages, the queue, the divider input register, 24 divider
//   stages (one quotient bit each) and the output register
// stalls
//   when m_tready is low while a result waits, the divider pipeline holds;
//   the front keeps taking items until the 4 deep queue fills, then s_tready falls
// reset
//   rst clears all valid flags and the queue; nothing else to set up
module segment_pair_intersection (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  logic [127:0]  s_tdata,
  output logic          m_tvalid,
  input  logic          m_tready,
  // cross_x, cross_y
  output logic [47:0]   m_tdata,
  // hit
  output logic          m_tuser
);

  logic              job_valid, job_full, job_pop, job_empty;
  spi_pkg::div_job_t job_in, job_out;
  logic [spi_pkg::OUT_BITS-1:0] res_x, res_y;

  spi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .job_valid (job_valid),
    .job_full  (job_full),
    .job       (job_in)
  );

  spi_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (job_valid),
    .push_data (job_in),
    .full      (job_full),
    .pop       (job_pop),
    .empty     (job_empty),
    .pop_data  (job_out)
  );

  spi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_avail (!job_empty),
    .job_pop   (job_pop),
    .job       (job_out),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_hit   (m_tuser),
    .out_x     (res_x),
    .out_y     (res_y)
  );

  assign m_tdata = {res_y, res_x};

endmodule

/* tb/segment_pair_intersection_tb.sv */
// self-checking testbench for the segment pair intersection block
// depends on spi_pkg and segment_pair_intersection; predicts each result in place
`timescale 1ns / 100ps

module segment_pair_intersection_tb;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic                         hit;
    logic [spi_pkg::OUT_BITS-1:0] cx;
    logic [spi_pkg::OUT_BITS-1:0] cy;
  } crossing_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [127:0]  s_tdata = '0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [47:0]   m_tdata;
  logic          m_tuser;

  crossing_t crossings_due[$];
  int        mismatches = 0;
  int        cycles = 0;
  int        hold_len = 0;
  int        held = 0;
  bit        rx_stall_on = 1'b1;

  segment_pair_intersection DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("segment_pair_intersection test failed");
      $finish;
    end
  end

  function automatic bit in_unit(longint num, longint den);
    if (den > 0) return num >= 0 && num <= den;
    return num <= 0 && num >= den;
  endfunction

  function automatic crossing_t crossing_of(logic [127:0] pair);
    longint c[8];
    longint rx, ry, sx, sy, dx, dy, rs, tn, un;
    crossing_t res;
    for (int i = 0; i < 8; i++) c[i] = longint'($signed(pair[16*i +: 16]));
    rx = c[2] - c[0]; ry = c[3] - c[1];
    sx = c[6] - c[4]; sy = c[7] - c[5];
    dx = c[4] - c[0]; dy = c[5] - c[1];
    rs = rx * sy - ry * sx;
    tn = dx * sy - dy * sx;
    un = dx * ry - dy * rx;
    res.hit = 1'b0; res.cx = '0; res.cy = '0;
    if (rs != 0 && in_unit(tn, rs) && in_unit(un, rs)) begin
      res.hit = 1'b1;
      res.cx = spi_pkg::OUT_BITS'(((c[0] * rs + tn * rx) *
                                   (64'sd1 << spi_pkg::SCALE_SH)) / rs);
      res.cy = spi_pkg::OUT_BITS'(((c[1] * rs + tn * ry) *
                                   (64'sd1 << spi_pkg::SCALE_SH)) / rs);
    end
    return res;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(9) < 6) return 0;
    if ($urandom_range(19) == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  task automatic send_pair(logic [127:0] pair);
    int g;
    g = rx_stall_on ? gap_len() : 0;
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pair;
    crossings_due.insert(crossings_due.size(), crossing_of(pair));
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_coords(int ax0, int ay0, int ax1, int ay1,
                             int bx0, int by0, int bx1, int by1);
    send_pair({16'(by1), 16'(bx1), 16'(by0), 16'(bx0),
               16'(ay1), 16'(ax1), 16'(ay0), 16'(ax0)});
  endtask

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (held < hold_len) begin
      m_tready <= 1'b0;
      held <= held + 1;
    end else if (rx_stall_on) begin
      m_tready <= ($urandom_range(9) < 7);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    crossing_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (crossings_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h %b", m_tdata, m_tuser);
      end else begin
        want = crossings_due.pop_front();
        if (m_tuser !== want.hit || m_tdata[23:0] !== want.cx || m_tdata[47:24] !== want.cy)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: hit %b x %h y %h, got hit %b x %h y %h",
                     want.hit, want.cx, want.cy, m_tuser, m_tdata[23:0], m_tdata[47:24]);
        end
      end
    end
  end

  task automatic test_directed();
    send_coords(-256, 0, 256, 0, 0, -256, 0, 256);
    send_coords(0, 0, 512, 512, 0, 512, 512, 0);
    send_coords(0, 0, 256, 0, 0, 256, 256, 256);
    send_coords(0, 0, 512, 0, 256, 0, 768, 0);
    send_coords(100, 100, 100, 100, 0, 0, 300, 300);
    send_coords(0, 0, 256, 0, 256, 0, 256, 256);
    send_coords(0, 0, 256, 0, 0, 0, 0, -256);
    send_coords(0, 0, 256, 0, 300, -10, 300, 10);
    send_coords(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    send_coords(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768);
    send_coords(-32768, 0, 32767, 1, 5, -32768, -3, 32767);
    send_coords(3, 7, -5, 11, 2, 12, -1, 5);
    send_coords(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    send_coords(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    send_pair({128{1'b1}});
    send_pair({8{16'h5555}});
    send_pair({8{16'haaaa}});
  endtask

  task automatic test_random(int n);
    int cx, cy, k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(3);
      if (k == 0) begin
        send_pair({$urandom, $urandom, $urandom, $urandom});
      end else begin
        // segments with ends on either side of a shared point so most of them cross
        cx = $urandom_range(2000) - 1000;
        cy = $urandom_range(2000) - 1000;
        send_coords(cx - int'($urandom_range(600)), cy - int'($urandom_range(600)),
                    cx + int'($urandom_range(600)), cy + int'($urandom_range(600)),
                    cx - int'($urandom_range(600)), cy + int'($urandom_range(600)),
                    cx + int'($urandom_range(600)), cy - int'($urandom_range(600)));
        if (k == 3) begin
          cx = 24000 - $urandom_range(48000);
          cy = 24000 - $urandom_range(48000);
          send_coords(cx - 8000, cy + int'($urandom_range(8000)), cx + 8000, cy - 500,
                      cx + int'($urandom_range(4000)), cy - 8000, cx - 300, cy + 8000);
        end
      end
    end
  endtask

  task automatic test_backpressure();
    rx_stall_on = 1'b0;
    hold_len = 300;
    test_random(60);
    rx_stall_on = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(350);
    test_backpressure();
    test_random(300);
    s_tvalid <= 1'b0;
    while (crossings_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("segment_pair_intersection test passed");
    end else begin
      $display("segment_pair_intersection test failed");
    end
    $finish;
  end

endmodule
